FILE: design/q8bdd_pkg.sv
// Shared types and constants for the Q8_0 block dequantising dot-product unit.
`timescale 1ns / 1ps
package q8bdd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_PACK,
    ST_ADD
  } state_e;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  localparam int unsigned MANT_W = 51;  // rounder input width
  localparam int unsigned EXP_W  = 12;  // signed exponent width
  localparam int unsigned SHL_W  = 7;   // rounder shift amount width

  typedef logic [MANT_W-1:0]        mant_t;
  typedef logic signed [EXP_W-1:0]  exp_t;

endpackage

FILE: design/q8_block_dequant_dot_product.sv
// Top level: sequential binary32 dequantise, multiply and accumulate unit.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o | scale_half_i, weight_q_i, act_bits_i, last_i
//  out     | out_valid_o/out_ready_i | sum_bits_o
//
// Each element steps through accept, multiply, normalise, pack, align-add,
// normalise, pack; the normalise/pack rounder is one unit used twice per element.
// A last element whose sum finds the output register still full waits in the
// final pack step until the earlier sum is taken.
// Reset clears the sequencer, the output valid and the accumulator to +0.0.
`timescale 1ns / 1ps
module q8_block_dequant_dot_product
  import q8bdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] scale_half_i,
  input  logic signed [7:0] weight_q_i,
  input  logic [31:0] act_bits_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o
);

  function automatic logic [5:0] lzc(input mant_t m);
    logic [5:0] z;
    z = 6'(MANT_W);
    for (int i = 0; i < MANT_W; i++) begin
      if (m[i]) z = 6'(MANT_W - 1 - i);
    end
    return z;
  endfunction

  state_e state_q, state_d;
  logic   phase_q, phase_d;
  logic   last_q;
  logic [15:0] h_q;
  logic [7:0]  q_q;
  logic [31:0] a_q;
  logic [18:0] hq_q;
  logic [31:0] prod_q, prod_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] sum_q, sum_d;
  logic        out_valid_q, out_valid_d;

  mant_t rm_q, rm_d;
  exp_t  re_q, re_d;
  logic  rs_q, rs_d;
  logic  spec_q, spec_d;
  logic [31:0] spec_bits_q, spec_bits_d;

  mant_t nm_q;
  logic [SHL_W-1:0] ns_q;
  logic [8:0] nef_q;
  logic nsign_q;

  logic in_acc, stall_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sum_bits_o  = sum_q;
  assign stall_out   = phase_q && last_q && out_valid_q && !out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL;
      ST_MUL:  state_d = ST_NORM;
      ST_NORM: state_d = ST_PACK;
      ST_PACK: begin
        if (!phase_q) state_d = ST_ADD;
        else if (!stall_out) state_d = ST_IDLE;
      end
      ST_ADD:  state_d = ST_NORM;
      default: state_d = ST_IDLE;
    endcase
  end

  // multiply step operands
  logic [4:0]  m_he;
  logic [7:0]  m_ae;
  logic [23:0] m_ax;
  logic [42:0] m_prod;
  exp_t        m_eh, m_ea;
  logic        h_inf, h_nan, h_zero, a_inf, a_nan, a_zero, q_zero, m_sign;

  always_comb begin
    m_he   = h_q[14:10];
    m_ae   = a_q[30:23];
    m_ax   = {(m_ae != 8'd0), a_q[22:0]};
    m_prod = 43'(hq_q) * 43'(m_ax);
    m_eh   = (m_he == 5'd0) ? -exp_t'(24) : exp_t'(m_he) - exp_t'(25);
    m_ea   = (m_ae == 8'd0) ? -exp_t'(149) : exp_t'(m_ae) - exp_t'(150);
    h_inf  = (m_he == 5'h1F) && (h_q[9:0] == 10'd0);
    h_nan  = (m_he == 5'h1F) && (h_q[9:0] != 10'd0);
    h_zero = (h_q[14:0] == 15'd0);
    a_inf  = (m_ae == 8'hFF) && (a_q[22:0] == 23'd0);
    a_nan  = (m_ae == 8'hFF) && (a_q[22:0] != 23'd0);
    a_zero = (a_q[30:0] == 31'd0);
    q_zero = (q_q == 8'd0);
    m_sign = h_q[15] ^ q_q[7] ^ a_q[31];
  end

  // align-add step
  logic [31:0] big, sml;
  logic [7:0]  eb, es, dd;
  logic [5:0]  dc;
  logic [49:0] bm, smf, smsh, smask;
  logic        sst;
  logic [50:0] asum;
  logic        ac_nan, ac_inf, pr_nan, pr_inf;

  always_comb begin
    if (acc_q[30:0] >= prod_q[30:0]) begin
      big = acc_q;
      sml = prod_q;
    end else begin
      big = prod_q;
      sml = acc_q;
    end
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dd    = eb - es;
    dc    = (dd > 8'd50) ? 6'd50 : dd[5:0];
    bm    = {(big[30:23] != 8'd0), big[22:0], 26'd0};
    smf   = {(sml[30:23] != 8'd0), sml[22:0], 26'd0};
    smsh  = smf >> dc;
    smask = (50'(1) << dc) - 50'(1);
    sst   = |(smf & smask);
    if (big[31] == sml[31]) asum = {1'b0, bm} + {1'b0, smsh | 50'(sst)};
    else                    asum = {1'b0, bm} - {1'b0, smsh | 50'(sst)};
    ac_nan = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0);
    ac_inf = (acc_q[30:0] == INF_MAG);
    pr_nan = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] != 23'd0);
    pr_inf = (prod_q[30:0] == INF_MAG);
  end

  // shared rounder, normalise half
  logic [5:0] n_p;
  exp_t       n_e;
  always_comb begin
    n_p = 6'(MANT_W - 1) - lzc(rm_q);
    n_e = re_q + exp_t'(n_p) + exp_t'(127);
  end

  // shared rounder, shift and pack half
  logic [75:0] p_x, p_y, p_mask;
  logic [23:0] p_m;
  logic        p_g, p_st, p_inc;
  logic [24:0] p_mr;
  logic [34:0] p_pk;
  logic [31:0] p_res;
  always_comb begin
    p_x    = {nm_q, 25'd0};
    p_y    = p_x >> ns_q;
    p_mask = (76'(1) << ns_q) - 76'(1);
    p_m    = p_y[25:2];
    p_g    = p_y[1];
    p_st   = p_y[0] | (|(p_x & p_mask));
    p_inc  = p_g & (p_st | p_m[0]);
    p_mr   = {1'b0, p_m} + 25'(p_inc);
    p_pk   = {3'd0, nef_q, 23'd0} + 35'(p_mr);
    if (nm_q == '0)                   p_res = {nsign_q, 31'd0};
    else if (p_pk[34:23] >= 12'd255)  p_res = {nsign_q, INF_MAG};
    else                              p_res = {nsign_q, p_pk[30:0]};
  end

  // datapath next values
  always_comb begin
    rm_d        = rm_q;
    re_d        = re_q;
    rs_d        = rs_q;
    spec_d      = spec_q;
    spec_bits_d = spec_bits_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: phase_d = 1'b0;
      ST_MUL: begin
        rm_d        = mant_t'(m_prod);
        re_d        = m_eh + m_ea;
        rs_d        = m_sign;
        spec_d      = 1'b1;
        spec_bits_d = {m_sign, INF_MAG};
        if (h_nan || a_nan || (h_inf && (q_zero || a_zero)) || (a_inf && (h_zero || q_zero)))
          spec_bits_d = CANON_NAN;
        else if (!(h_inf || a_inf))
          spec_d = 1'b0;
      end
      ST_ADD: begin
        rm_d        = asum;
        re_d        = exp_t'(eb) - exp_t'(176);
        rs_d        = (asum == '0) ? (acc_q[31] & prod_q[31]) : big[31];
        phase_d     = 1'b1;
        spec_d      = ac_nan || pr_nan || ac_inf || pr_inf;
        if (ac_nan || pr_nan || (ac_inf && pr_inf && (acc_q[31] != prod_q[31])))
          spec_bits_d = CANON_NAN;
        else if (ac_inf)
          spec_bits_d = acc_q;
        else
          spec_bits_d = prod_q;
      end
      ST_PACK: begin
        if (!phase_q) begin
          prod_d = spec_q ? spec_bits_q : p_res;
        end else if (!stall_out) begin
          acc_d = spec_q ? spec_bits_q : p_res;
          if (last_q) begin
            sum_d       = acc_d;
            acc_d       = 32'd0;
            out_valid_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 32'd0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q    <= scale_half_i;
      q_q    <= weight_q_i;
      a_q    <= act_bits_i;
      last_q <= last_i;
      // weight magnitude is unsigned, so -128 widens to 128
      hq_q   <= 19'({(scale_half_i[14:10] != 5'd0), scale_half_i[9:0]})
              * 19'($unsigned(weight_q_i[7] ? 8'(-weight_q_i) : 8'(weight_q_i)));
    end
    rm_q        <= rm_d;
    re_q        <= re_d;
    rs_q        <= rs_d;
    spec_q      <= spec_d;
    spec_bits_q <= spec_bits_d;
    prod_q      <= prod_d;
    sum_q       <= sum_d;
    if (state_q == ST_NORM) begin
      nm_q    <= rm_q;
      nsign_q <= rs_q;
      if (n_e >= exp_t'(1)) begin
        ns_q  <= SHL_W'(n_p);
        nef_q <= 9'(n_e - exp_t'(1));
      end else begin
        ns_q  <= SHL_W'(-exp_t'(126) - re_q);
        nef_q <= 9'd0;
      end
    end
  end

endmodule

FILE: design/q8bdd_checker.sv
// Port-level checker for the dot-product unit, bound to the top level.
`timescale 1ns / 1ps
module q8bdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] sum_bits_o
);

  // pending result holds until its transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sum_bits_o))
    else $error("output dropped or changed while stalled");

  // sequencer stays busy after an input transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken while element still in flight");

  // only the canonical quiet NaN leaves the block
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sum_bits_o[30:23] == 8'hFF) && (sum_bits_o[22:0] != 23'd0)
      |-> sum_bits_o == 32'h7FC0_0000)
    else $error("non-canonical NaN on output");

  // a new result is raised only out of a busy sequencer, never from idle
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a finished element");

endmodule

bind q8_block_dequant_dot_product q8bdd_checker u_q8bdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sum_bits_o  (sum_bits_o)
);

FILE: tb/sv/q8_block_dequant_dot_product_tb.sv
// Self-checking testbench for the Q8_0 dequantising dot-product unit.
`timescale 1ns / 1ps
module q8_block_dequant_dot_product_tb
  import q8bdd_pkg::*;
;

  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [15:0]        scale_half_i;
  logic signed [7:0]  weight_q_i;
  logic [31:0]        act_bits_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        sum_bits_o;

  q8_block_dequant_dot_product dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .scale_half_i(scale_half_i),
    .weight_q_i  (weight_q_i),
    .act_bits_i  (act_bits_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sum_bits_o  (sum_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  logic [31:0] sum_expected_q[$];
  logic [31:0] running_sum;
  int          accepted_cnt;
  int          offered_cnt;
  int          error_cnt;
  int          idle_cycles;
  int          burst_left;
  bit          steady_send;
  int          hold_req;
  int          hold_left;
  int          stall_mode;

  // ---------------------------------------------------------------- predictor

  function automatic real f32_bits_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
    end
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == 23'b0) return $bitstoreal({b[31], 63'b0});
      r = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) + 896), b[22:0], 29'b0});
  endfunction

  function automatic real half_bits_to_real(logic [15:0] h);
    real r;
    if (h[14:10] == 5'h1F) begin
      return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'b0});
    end
    if (h[14:10] == 5'h00) begin
      if (h[9:0] == 10'b0) return $bitstoreal({h[15], 63'b0});
      r = real'(h[9:0]) * (2.0 ** -24);
      return h[15] ? -r : r;
    end
    return $bitstoreal({h[15], 11'(int'(h[14:10]) + 1008), h[9:0], 42'b0});
  endfunction

  // Round an exact (or innocuously pre-rounded) double to binary32, RNE.
  function automatic logic [31:0] round_to_f32(real r);
    logic [63:0] d;
    logic [63:0] full;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] halfway;
    int          fexp;
    int          shift;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F80_0000};
    end
    if (d[62:0] == 63'b0) return {d[63], 31'b0};
    full = {11'b0, 1'b1, d[51:0]};
    fexp = int'(d[62:52]) - 1023 + 127;
    shift = (fexp >= 1) ? 29 : 29 + 1 - fexp;
    if (shift > 54) return {d[63], 31'b0};
    kept = full >> shift;
    rem = full & ((64'd1 << shift) - 1);
    halfway = 64'd1 << (shift - 1);
    if (rem > halfway || (rem == halfway && kept[0])) kept++;
    if (fexp < 1) return {d[63], kept[30:0]};
    if (kept == (64'd1 << 24)) begin
      kept = kept >> 1;
      fexp++;
    end
    if (fexp >= 255) return {d[63], 31'h7F80_0000};
    return {d[63], 8'(fexp), kept[22:0]};
  endfunction

  // Folds one element into the running sum; returns 1 with the sum when last.
  function automatic bit fold_element(logic [15:0] h, logic signed [7:0] q,
                                      logic [31:0] a, logic fin, output logic [31:0] sum);
    logic [31:0] prod;
    prod = round_to_f32((half_bits_to_real(h) * real'(int'(q))) * f32_bits_to_real(a));
    running_sum = round_to_f32(f32_bits_to_real(running_sum) + f32_bits_to_real(prod));
    sum = running_sum;
    if (!fin) return 1'b0;
    if (running_sum[30:23] == 8'hFF && running_sum[22:0] != 0) sum = CANON_NAN;
    running_sum = 32'h0;
    return 1'b1;
  endfunction

  // ------------------------------------------------ transaction monitor/checker

  always @(posedge clk_i) begin
    logic [31:0] sum;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (sum_expected_q.size() == 0) begin
          $error("sum_bits: unexpected result %h", sum_bits_o);
          error_cnt++;
        end else begin
          sum = sum_expected_q.pop_front();
          if (sum_bits_o !== sum) begin
            $error("sum_bits: expected %h, actual %h", sum, sum_bits_o);
            error_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        if (fold_element(scale_half_i, weight_q_i, act_bits_i, last_i, sum))
          sum_expected_q.push_back(sum);
        accepted_cnt++;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        2:       out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_element(logic [15:0] h, logic [7:0] q, logic [31:0] a, logic fin);
    int gap;
    int target;
    if (burst_left == 0) begin
      gap = steady_send ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    scale_half_i <= h;
    weight_q_i   <= q;
    act_bits_i   <= a;
    last_i       <= fin;
    offered_cnt++;
    target = offered_cnt;
    wait (accepted_cnt == target);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_scale();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(8, 18)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] rand_act();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(110, 135)), 23'($urandom)};
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_special_values();
    send_element(16'h7BFF, 8'sd127, 32'h7F7F_FFFF, 1'b1);   // overflow to infinity
    send_element(16'h0001, 8'h80, 32'h0000_0001, 1'b1);     // underflow to zero
    send_element(16'h0001, 8'sd1, 32'h3F80_0000, 1'b1);     // half subnormal
    send_element(16'h3C00, 8'sd1, 32'h0000_0001, 1'b1);     // single subnormal
    send_element(16'h8000, 8'sd1, 32'h3F80_0000, 1'b0);     // negative zeros only
    send_element(16'h3C00, 8'sd0, 32'hBF80_0000, 1'b1);
    send_element(16'h7C00, 8'sd0, 32'h3F80_0000, 1'b1);     // inf * 0
    send_element(16'h7C00, 8'sd1, 32'h3F80_0000, 1'b0);     // inf - inf
    send_element(16'hFC00, 8'sd1, 32'h3F80_0000, 1'b1);
    send_element(16'h7E00, 8'sd3, 32'h4000_0000, 1'b1);     // half NaN
    send_element(16'h3C00, 8'sd2, 32'h7FC0_1234, 1'b1);     // single NaN
    send_element(16'h3C00, 8'sd1, 32'hFF80_0000, 1'b1);     // -inf
    send_element(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_element(16'h3C00, 8'sd1, 32'h4B80_0000, 1'b0);     // tie rounding in the add
    send_element(16'h3C00, 8'sd1, 32'h3F80_0000, 1'b0);
    send_element(16'h3C00, 8'sd1, 32'h3F80_0000, 1'b1);
    send_element(16'h3555, 8'sd127, 32'h3EAA_AAAB, 1'b0);
    send_element(16'hB555, 8'h80, 32'hC0490FDB, 1'b1);
    send_element(16'h0000, 8'sd0, 32'h0000_0000, 1'b1);
  endtask

  task automatic send_dot_products(int n_elems, int max_len);
    int left;
    int len;
    left = n_elems;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      left -= len;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_element(16'($urandom), 8'($urandom), $urandom, 1'($urandom));  // noise
        else
          send_element(rand_scale(), 8'($urandom), rand_act(), i == len - 1);
      end
    end
  endtask

  task automatic test_output_backpressure();
    // Receiver holds off while the sender keeps offering short dot products.
    steady_send = 1'b1;
    hold_req = LONG_HOLD;
    send_dot_products(40, 3);
    steady_send = 1'b0;
  endtask

  task automatic test_random_dot_products();
    send_dot_products(200, 32);
    steady_send = 1'b1;
    send_dot_products(60, 8);
    steady_send = 1'b0;
    send_dot_products(200, 6);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    scale_half_i = '0;
    weight_q_i   = '0;
    act_bits_i   = '0;
    last_i       = 1'b0;
    out_ready_i  = 1'b0;
    running_sum  = 32'h0;
    accepted_cnt = 0;
    offered_cnt  = 0;
    error_cnt    = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    steady_send  = 1'b0;
    hold_req     = 0;
    hold_left    = 0;
    stall_mode   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_special_values();
    test_output_backpressure();
    test_random_dot_products();
    in_valid_i <= 1'b0;

    wait (sum_expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && sum_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
